### design/prw_pkg.sv
// shared types, constants and helpers for the prewitt edge threshold block
package prw_pkg;

    // pixel and geometry widths
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int THR_W      = 9;
    localparam int POS_W      = 10;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDE_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W      = ((WIDE_W > DIM_W) ? WIDE_W : DIM_W) + 1;
    localparam int SUM_W      = PIX_W + 2;
    localparam int NUM_CELLS  = 2;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(1024);
    localparam logic [DIM_W-1:0] HEIGHT_RESET    = DIM_W'(1024);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = '0;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } reg_idx_t;

    // one column of the 3x3 window
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } pix_col_t;

    // full window, left is column c-2, right is the incoming column
    typedef struct packed {
        pix_col_t left;
        pix_col_t center;
        pix_col_t right;
    } win_t;

    // position info that travels with a window
    typedef struct packed {
        logic             produce;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } pos_t;

    // one result transaction
    typedef struct packed {
        logic             edge_res;
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
        logic             frame_end;
    } res_t;

    // clamp an image dimension to 3..maxv
    function automatic logic [CMP_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                   logic [CMP_W-1:0] maxv);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve < CMP_W'(3))
            return CMP_W'(3);
        else if (ve > maxv)
            return maxv;
        else
            return ve;
    endfunction

endpackage

### design/prw_pix_if.sv
// pixel input channel
interface prw_pix_if;
    logic                     valid;
    logic                     ready;
    logic [prw_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

### design/prw_res_if.sv
// edge result output channel
interface prw_res_if;
    logic                      valid;
    logic                      ready;
    logic                      edge_res;
    logic [prw_pkg::POS_W-1:0] center_row;
    logic [prw_pkg::POS_W-1:0] center_col;
    logic                      frame_end;

    modport source (output valid, output edge_res, output center_row,
                    output center_col, output frame_end, input ready);
    modport sink   (input valid, input edge_res, input center_row,
                    input center_col, input frame_end, output ready);
endinterface

### design/prewitt_edge_threshold_core.sv
// top level of the streaming prewitt edge threshold block
// Takes one 8-bit grey pixel per clock in raster order and returns, for every
// interior pixel, an edge flag with the window center's row and column; border
// pixels give no transaction. Pixels are accepted back to back at one per cycle:
// the line memories are read one column ahead so each accepted pixel costs one
// read and one write of a single port pair, and the window is a row of two
// column cells that shift on every accepted pixel. A result is registered into
// the output buffer when its pixel is accepted; a two-entry output buffer keeps
// input flowing while a result waits, and input ready drops only when both
// entries are full. Line memory contents after reset are masked to zero by a
// fill count, so there is no clearing pass and the block is ready as soon as
// reset is released. Change geometry or threshold only while idle.
module prewitt_edge_threshold_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    prw_pix_if.sink                       pix,
    prw_res_if.source                     res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prw_pkg::PADDR_W-1:0]   paddr,
    input  logic [prw_pkg::PDATA_W-1:0]   pwdata,
    output logic [prw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CMP_W = prw_pkg::CMP_W;
    localparam int COL_W = prw_pkg::COL_W;
    localparam int ROW_W = prw_pkg::ROW_W;

    logic [prw_pkg::DIM_W-1:0] width_reg;
    logic [prw_pkg::DIM_W-1:0] height_reg;
    logic [prw_pkg::THR_W-1:0] threshold_reg;
    logic [COL_W-1:0]          col_reg;
    logic [COL_W-1:0]          col_next;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;
    logic [CMP_W-1:0]          w_eff;
    logic [CMP_W-1:0]          h_eff;
    logic [CMP_W-1:0]          col_inc;
    logic [CMP_W-1:0]          row_inc;
    logic                      col_wrap;
    logic                      row_wrap;
    logic                      accept;
    logic                      cfg_write;
    prw_pkg::reg_idx_t         reg_idx;
    logic [prw_pkg::PIX_W-1:0] lb_top;
    logic [prw_pkg::PIX_W-1:0] lb_mid;
    prw_pkg::pix_col_t         cell_col [prw_pkg::NUM_CELLS+1];
    prw_pkg::win_t             win;
    prw_pkg::pos_t             pos;
    prw_pkg::res_t             out_res;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = prw_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (reg_idx)
            prw_pkg::REG_IMAGE_WIDTH:    prdata = prw_pkg::PDATA_W'(width_reg);
            prw_pkg::REG_IMAGE_HEIGHT:   prdata = prw_pkg::PDATA_W'(height_reg);
            prw_pkg::REG_EDGE_THRESHOLD: prdata = prw_pkg::PDATA_W'(threshold_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= prw_pkg::WIDTH_RESET;
            height_reg    <= prw_pkg::HEIGHT_RESET;
            threshold_reg <= prw_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                prw_pkg::REG_IMAGE_WIDTH:
                    width_reg <= pwdata[prw_pkg::DIM_W-1:0];
                prw_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= pwdata[prw_pkg::DIM_W-1:0];
                prw_pkg::REG_EDGE_THRESHOLD:
                    threshold_reg <= pwdata[prw_pkg::THR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // raster position of the next pixel
    assign accept   = pix.valid && pix.ready;
    assign w_eff    = prw_pkg::clamp_dim(width_reg, CMP_W'(prw_pkg::MAX_WIDTH));
    assign h_eff    = prw_pkg::clamp_dim(height_reg, CMP_W'(prw_pkg::MAX_HEIGHT));
    assign col_inc  = CMP_W'(col_reg) + 1'b1;
    assign row_inc  = CMP_W'(row_reg) + 1'b1;
    assign col_wrap = (col_inc >= w_eff);
    assign row_wrap = (row_inc >= h_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memories
    prw_line_buf u_line_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .cur_col  (col_reg),
        .next_col (col_next),
        .bot      (pix.pixel),
        .top      (lb_top),
        .mid      (lb_mid)
    );

    // window column cells, fed by the incoming column
    assign cell_col[0] = '{top: lb_top, mid: lb_mid, bot: pix.pixel};

    for (genvar i = 0; i < prw_pkg::NUM_CELLS; i++)
    begin : g_cell
        prw_col_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .col_in   (cell_col[i]),
            .col_out  (cell_col[i+1])
        );
    end

    assign win.right  = cell_col[0];
    assign win.center = cell_col[1];
    assign win.left   = cell_col[2];

    // position of the window center
    always_comb
    begin
        pos.produce = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        pos.row     = prw_pkg::POS_W'(row_reg - 1'b1);
        pos.col     = prw_pkg::POS_W'(col_reg - 1'b1);
        pos.last    = row_wrap && col_wrap;
    end

    // gradient and output buffer
    prw_grad u_grad
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (accept),
        .win       (win),
        .pos       (pos),
        .threshold (threshold_reg),
        .in_ready  (pix.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_res   (out_res)
    );

    assign res.edge_res   = out_res.edge_res;
    assign res.center_row = out_res.center_row;
    assign res.center_col = out_res.center_col;
    assign res.frame_end  = out_res.frame_end;

endmodule

### design/prw_line_buf.sv
// two line memories with prefetched read and fill-count zero masking
module prw_line_buf
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [prw_pkg::COL_W-1:0]    cur_col,
    input  logic [prw_pkg::COL_W-1:0]    next_col,
    input  logic [prw_pkg::PIX_W-1:0]    bot,
    output logic [prw_pkg::PIX_W-1:0]    top,
    output logic [prw_pkg::PIX_W-1:0]    mid
);

    logic [prw_pkg::PIX_W-1:0] mem_older [prw_pkg::MAX_WIDTH];
    logic [prw_pkg::PIX_W-1:0] mem_newer [prw_pkg::MAX_WIDTH];
    logic [prw_pkg::PIX_W-1:0] rd_older_reg;
    logic [prw_pkg::PIX_W-1:0] rd_newer_reg;
    logic [prw_pkg::COL_W:0]   fill_reg;
    logic [prw_pkg::COL_W:0]   fill_next;
    logic [prw_pkg::COL_W-1:0] rd_addr;
    logic                      cur_valid;

    // read the column of the next pixel ahead of its arrival
    assign rd_addr = wr_en ? next_col : cur_col;

    // columns are always written from zero upward, so written entries form a prefix
    assign cur_valid = ({1'b0, cur_col} < fill_reg);
    assign top       = cur_valid ? rd_older_reg : '0;
    assign mid       = cur_valid ? rd_newer_reg : '0;

    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && ({1'b0, cur_col} >= fill_reg))
            fill_next = {1'b0, cur_col} + 1'b1;
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_older[cur_col] <= mid;
            mem_newer[cur_col] <= bot;
        end
        rd_older_reg <= mem_older[rd_addr];
        rd_newer_reg <= mem_newer[rd_addr];
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

endmodule

### design/prw_col_cell.sv
// one window column cell, shifts toward its neighbor on each pixel
module prw_col_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  prw_pkg::pix_col_t col_in,
    output prw_pkg::pix_col_t col_out
);

    prw_pkg::pix_col_t col_reg;

    assign col_out = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else if (shift_en)
            col_reg <= col_in;
    end

endmodule

### design/prw_grad.sv
// prewitt sums, clamp, threshold and two-entry result buffer
module prw_grad
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_accept,
    input  prw_pkg::win_t             win,
    input  prw_pkg::pos_t             pos,
    input  logic [prw_pkg::THR_W-1:0] threshold,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output prw_pkg::res_t             out_res
);

    localparam int DIFF_W = prw_pkg::SUM_W + 1;

    logic [prw_pkg::SUM_W-1:0]  left_sum;
    logic [prw_pkg::SUM_W-1:0]  right_sum;
    logic [prw_pkg::SUM_W-1:0]  up_sum;
    logic [prw_pkg::SUM_W-1:0]  down_sum;
    logic signed [DIFF_W-1:0]   gx_raw;
    logic signed [DIFF_W-1:0]   gy_raw;
    logic [prw_pkg::PIX_W-1:0]  gx;
    logic [prw_pkg::PIX_W-1:0]  gy;
    logic [prw_pkg::PIX_W:0]    g_sum;
    prw_pkg::res_t              new_res;
    logic                       push;
    logic                       pop;
    prw_pkg::res_t              head_reg;
    prw_pkg::res_t              skid_reg;
    logic                       head_valid_reg;
    logic                       skid_valid_reg;

    // clamp a signed difference to the byte range
    function automatic logic [prw_pkg::PIX_W-1:0] clamp_byte(logic signed [DIFF_W-1:0] v);
        if (v < 0)
            return '0;
        else if (v > DIFF_W'(255))
            return '1;
        else
            return v[prw_pkg::PIX_W-1:0];
    endfunction

    // column and row sums
    assign left_sum  = prw_pkg::SUM_W'(win.left.top) + prw_pkg::SUM_W'(win.left.mid)
                     + prw_pkg::SUM_W'(win.left.bot);
    assign right_sum = prw_pkg::SUM_W'(win.right.top) + prw_pkg::SUM_W'(win.right.mid)
                     + prw_pkg::SUM_W'(win.right.bot);
    assign up_sum    = prw_pkg::SUM_W'(win.left.top) + prw_pkg::SUM_W'(win.center.top)
                     + prw_pkg::SUM_W'(win.right.top);
    assign down_sum  = prw_pkg::SUM_W'(win.left.bot) + prw_pkg::SUM_W'(win.center.bot)
                     + prw_pkg::SUM_W'(win.right.bot);

    // gradients, clamped and compared
    assign gx_raw = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    assign gy_raw = $signed({1'b0, down_sum}) - $signed({1'b0, up_sum});
    assign gx     = clamp_byte(gx_raw);
    assign gy     = clamp_byte(gy_raw);
    assign g_sum  = {1'b0, gx} + {1'b0, gy};

    always_comb
    begin
        new_res.edge_res   = (g_sum > threshold);
        new_res.center_row = pos.row;
        new_res.center_col = pos.col;
        new_res.frame_end  = pos.last;
    end

    // buffer handshake
    assign push      = in_accept && pos.produce;
    assign pop       = head_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_res   = head_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                head_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
                head_reg <= new_res;
            else
                skid_reg <= new_res;
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (head_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            head_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            head_valid_reg <= 1'b0;
        end
    end

endmodule

### design/prw_checker.sv
// port-level checker for the prewitt edge threshold block and its bind
module prw_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pix_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic                      res_edge,
    input logic [prw_pkg::POS_W-1:0] res_row,
    input logic [prw_pkg::POS_W-1:0] res_col,
    input logic                      res_frame_end
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable({res_edge, res_row, res_col, res_frame_end}))
        else $error("result payload changed while stalled");

    // border pixels never produce a result
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_row != '0) && (res_col != '0))
        else $error("result for a border pixel");

    // input backpressure only while a result is waiting
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid)
        else $error("input stalled with no pending result");

endmodule

bind prewitt_edge_threshold_core prw_checker u_prw_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_ready     (pix.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_edge      (res.edge_res),
    .res_row       (res.center_row),
    .res_col       (res.center_col),
    .res_frame_end (res.frame_end)
);

### tb/tb_prewitt_edge_threshold_core.sv
// testbench for the prewitt edge threshold core with scoreboard and stream drivers
module tb_prewitt_edge_threshold_core;
    timeunit 1ns;
    timeprecision 1ps;

    import prw_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 300;
    localparam int TALL_PIXELS   = 30;

    // expected edge results, built from a software copy of the line stores and window
    class edge_scoreboard;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [THR_W-1:0] thr_reg;
        logic [PIX_W-1:0] older_row [MAX_WIDTH];
        logic [PIX_W-1:0] newer_row [MAX_WIDTH];
        logic [PIX_W-1:0] win [6];
        int               row_pos;
        int               col_pos;
        res_t             pending_edges [$];
        int               errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            thr_reg    = THRESHOLD_RESET;
            foreach (older_row[i]) older_row[i] = '0;
            foreach (newer_row[i]) newer_row[i] = '0;
            foreach (win[i]) win[i] = '0;
            row_pos = 0;
            col_pos = 0;
            errors  = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH:    width_reg  = value[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg = value[DIM_W-1:0];
                REG_EDGE_THRESHOLD: thr_reg    = value[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the window by one accepted pixel and queue its result, if any
        function void note_pixel(logic [PIX_W-1:0] bot);
            int               w;
            int               h;
            int               left;
            int               right;
            int               up;
            int               down;
            int               gx;
            int               gy;
            logic [PIX_W-1:0] top;
            logic [PIX_W-1:0] mid;
            res_t             exp_res;
            w = (int'(width_reg) < 3) ? 3 :
                (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            h = (int'(height_reg) < 3) ? 3 :
                (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
            top = older_row[col_pos];
            mid = newer_row[col_pos];

            // full window: gradient sums clamped to a byte each
            if (row_pos >= 2 && col_pos >= 2)
            begin
                left  = int'(win[0]) + int'(win[1]) + int'(win[2]);
                right = int'(top) + int'(mid) + int'(bot);
                up    = int'(win[0]) + int'(win[3]) + int'(top);
                down  = int'(win[2]) + int'(win[5]) + int'(bot);
                gx = right - left;
                gx = (gx < 0) ? 0 : (gx > 255) ? 255 : gx;
                gy = down - up;
                gy = (gy < 0) ? 0 : (gy > 255) ? 255 : gy;
                exp_res.edge_res   = (gx + gy > int'(thr_reg));
                exp_res.center_row = POS_W'(row_pos - 1);
                exp_res.center_col = POS_W'(col_pos - 1);
                exp_res.frame_end  = (row_pos + 1 >= h) && (col_pos + 1 >= w);
                pending_edges.push_back(exp_res);
            end

            // shift window columns and update line stores
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = bot;
            older_row[col_pos] = mid;
            newer_row[col_pos] = bot;

            // raster position with wrap on current geometry
            if (col_pos + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
            end
            else
            begin
                col_pos = col_pos + 1;
            end
        endfunction

        function void check_result(res_t got);
            res_t exp_res;
            if (pending_edges.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: edge=%0d row=%0d col=%0d end=%0d",
                             got.edge_res, got.center_row, got.center_col, got.frame_end);
                return;
            end
            exp_res = pending_edges.pop_front();
            if (got.edge_res !== exp_res.edge_res || got.center_row !== exp_res.center_row ||
                got.center_col !== exp_res.center_col || got.frame_end !== exp_res.frame_end)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected edge=%0d row=%0d col=%0d end=%0d,",
                             exp_res.edge_res, exp_res.center_row, exp_res.center_col,
                             exp_res.frame_end,
                             " got edge=%0d row=%0d col=%0d end=%0d",
                             got.edge_res, got.center_row,
                             got.center_col, got.frame_end);
            end
        endfunction

        function int pending();
            return pending_edges.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    prw_pix_if pix_ch ();
    prw_res_if res_ch ();

    edge_scoreboard sb;
    int             cycles;
    int             send_run;
    bit             send_idle_on;

    // directed frames for a 3x3 image
    logic [PIX_W-1:0] frame_down_step [9] = '{0, 0, 0, 0, 0, 0, 255, 255, 255};
    logic [PIX_W-1:0] frame_left_wall [9] = '{255, 0, 0, 255, 0, 0, 255, 0, 0};
    logic [PIX_W-1:0] frame_corner    [9] = '{0, 0, 0, 0, 0, 255, 0, 255, 255};

    prewitt_edge_threshold_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // register write: setup then access phase
    task automatic write_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(4 * int'(idx));
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
    endtask

    // one pixel transaction with a random lead-in gap
    task automatic send_pixel(logic [PIX_W-1:0] value);
        int gap;
        if (send_run == 0)
        begin
            send_run     = $urandom_range(10, 60);
            send_idle_on = ($urandom_range(0, 3) != 0);
        end
        send_run--;
        gap = send_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            pix_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid = 1'b1;
        pix_ch.pixel = value;
        do @(posedge clk); while (!pix_ch.ready);
        sb.note_pixel(value);
        @(negedge clk);
    endtask

    // stop sending and wait until every expected result has come out
    task automatic settle_pipeline();
        pix_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // result side: random stalls, check every transaction
    initial
    begin : result_sink
        int   stall;
        int   run_left;
        bit   idle_on;
        res_t got;
        run_left = 0;
        idle_on  = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(10, 60);
                idle_on  = ($urandom_range(0, 3) != 0);
            end
            run_left--;
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            got.edge_res   = res_ch.edge_res;
            got.center_row = res_ch.center_row;
            got.center_col = res_ch.center_col;
            got.frame_end  = res_ch.frame_end;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin : stimulus
        int               random_sent;
        int               count;
        int               pattern;
        logic [PDATA_W-1:0] wsel;
        logic [PDATA_W-1:0] hsel;
        logic [PDATA_W-1:0] thr;
        logic [PIX_W-1:0] value;
        sb = new();
        cycles       = 0;
        send_run     = 0;
        send_idle_on = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // smallest image: saturated vertical gradient at threshold zero
        write_register(REG_IMAGE_WIDTH, 3);
        write_register(REG_IMAGE_HEIGHT, 3);
        write_register(REG_EDGE_THRESHOLD, 0);
        foreach (frame_down_step[i]) send_pixel(frame_down_step[i]);
        settle_pipeline();

        // negative horizontal gradient clamps to zero
        write_register(REG_EDGE_THRESHOLD, 254);
        foreach (frame_left_wall[i]) send_pixel(frame_left_wall[i]);
        settle_pipeline();

        // threshold above a byte, both gradients saturated
        write_register(REG_EDGE_THRESHOLD, 256);
        foreach (frame_corner[i]) send_pixel(frame_corner[i]);
        settle_pipeline();

        // widest row: oversized width clamps to the maximum, then two narrow rows
        write_register(REG_IMAGE_WIDTH, 2047);
        write_register(REG_IMAGE_HEIGHT, 3);
        write_register(REG_EDGE_THRESHOLD, $urandom_range(0, 300));
        repeat (MAX_WIDTH) send_pixel(PIX_W'($urandom_range(0, 255)));
        settle_pipeline();
        write_register(REG_IMAGE_WIDTH, 3);
        repeat (6) send_pixel(PIX_W'($urandom_range(0, 255)));
        settle_pipeline();

        // narrowest row in a tall frame
        write_register(REG_IMAGE_WIDTH, 3);
        write_register(REG_IMAGE_HEIGHT, MAX_HEIGHT);
        write_register(REG_EDGE_THRESHOLD, $urandom_range(0, 300));
        repeat (TALL_PIXELS) send_pixel(PIX_W'($urandom_range(0, 255)));
        settle_pipeline();

        // random phases; geometry often changes mid-frame
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       wsel = $urandom_range(0, 2);
                    1:       wsel = $urandom_range(1025, 2047);
                    2:       wsel = $urandom_range(13, 40);
                    default: wsel = $urandom_range(3, 12);
                endcase
                case ($urandom_range(0, 9))
                    0:       hsel = $urandom_range(0, 2);
                    1:       hsel = $urandom_range(1025, 2047);
                    default: hsel = $urandom_range(3, 8);
                endcase
                write_register(REG_IMAGE_WIDTH, wsel);
                write_register(REG_IMAGE_HEIGHT, hsel);
            end
            case ($urandom_range(0, 3))
                0:       thr = 0;
                1:       thr = $urandom_range(0, 511);
                default: thr = $urandom_range(0, 300);
            endcase
            write_register(REG_EDGE_THRESHOLD, thr);

            pattern = $urandom_range(0, 3);
            count   = $urandom_range(20, 150);
            for (int n = 0; n < count; n++)
            begin
                case (pattern)
                    0:       value = PIX_W'($urandom_range(0, 255));
                    1:       value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    2:       value = PIX_W'(120 + $urandom_range(0, 16));
                    default: value = PIX_W'(n * 17 + $urandom_range(0, 3));
                endcase
                // occasional full drain in the middle of a phase
                if ($urandom_range(0, 199) == 0)
                    settle_pipeline();
                send_pixel(value);
            end
            random_sent += count;
            settle_pipeline();
        end

        settle_pipeline();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### prewitt_edge_threshold_core.f
design/prw_pkg.sv
design/prw_pix_if.sv
design/prw_res_if.sv
design/prw_line_buf.sv
design/prw_col_cell.sv
design/prw_grad.sv
design/prewitt_edge_threshold_core.sv
design/prw_checker.sv
tb/tb_prewitt_edge_threshold_core.sv
